@@ rtl/tdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tdsc_pkg
// Types and constants shared by the timer divider setting calculator.
// ----------------------------------------------------------------------------
package tdsc_pkg;

  // Dividend (module clock) and divisor (tick rate) widths
  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 20;

  localparam logic [DivisorW-1:0]  TickRateHz   = 20'd1000000;
  localparam logic [DividendW-1:0] DivLimitFull = 32'(256 * 256 * 16);
  localparam logic [6:0]           ScaledTopBit = 7'd15;
  // Period bit length at which the tick rate drops to zero
  localparam logic [6:0]           RateZeroLen  = 7'd35;

  // Clock select field, mode word bits 2:1
  localparam logic [1:0] ClkNormal = 2'd1;
  localparam logic [1:0] ClkSlow   = 2'd2;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StDivRange = 2'd1,
    StRateZero = 2'd2
  } status_e;

  typedef enum logic {
    RegClockHz     = 1'b0,
    RegHasPrimary  = 1'b1
  } reg_idx_e;

  // Request data that rides along the divider pipeline
  typedef struct packed {
    logic        rate_zero;
    logic        reload;
    logic [15:0] ref_val;
  } side_t;

endpackage

@@ rtl/tdsc_req_if.sv @@
// ----------------------------------------------------------------------------
// tdsc_req_if
// Request channel: one timer period request per word.
// ----------------------------------------------------------------------------
interface tdsc_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] period_us;
  logic        reload;

  modport source (output valid, output cmd, output period_us, output reload, input ready);
  modport sink   (input valid, input cmd, input period_us, input reload, output ready);
endinterface

@@ rtl/tdsc_res_if.sv @@
// ----------------------------------------------------------------------------
// tdsc_res_if
// Result channel: one set of timer channel settings per word.
// ----------------------------------------------------------------------------
interface tdsc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] mode_word;
  logic [7:0]  primary_prescale;
  logic [15:0] reference;

  modport source (output valid, output status, output mode_word, output primary_prescale,
                  output reference, input ready);
  modport sink   (input valid, input status, input mode_word, input primary_prescale,
                  input reference, output ready);
endinterface

@@ rtl/tdsc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// tdsc_div_pipe
// Pipelined restoring divider: module clock over tick rate, BitsPerStage
// quotient bits per stage, with per-stage valid and ready.
// ----------------------------------------------------------------------------
module tdsc_div_pipe #(
  parameter int unsigned BitsPerStage = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [tdsc_pkg::DividendW-1:0]     dividend_i,
  input  logic [tdsc_pkg::DivisorW-1:0]      divisor_i,
  input  tdsc_pkg::side_t                    side_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [tdsc_pkg::DividendW-1:0]     quotient_o,
  output tdsc_pkg::side_t                    side_o
);

  localparam int unsigned NW        = tdsc_pkg::DividendW;
  localparam int unsigned RW        = tdsc_pkg::DivisorW;
  localparam int unsigned NumStages = NW / BitsPerStage;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;
  logic [NW-1:0]        num_q [NumStages];
  logic [RW-1:0]        rem_q [NumStages];
  logic [RW-1:0]        dsr_q [NumStages];
  tdsc_pkg::side_t      side_q [NumStages];

  assign rdy[NumStages] = ready_i;
  assign ready_o        = rdy[0];

  genvar s;
  for (s = 0; s < NumStages; s++) begin : g_stage
    logic            src_v;
    logic [NW-1:0]   src_num;
    logic [RW-1:0]   src_rem;
    logic [RW-1:0]   src_dsr;
    tdsc_pkg::side_t src_side;
    logic [NW-1:0]   nxt_num;
    logic [RW-1:0]   nxt_rem;

    if (s == 0) begin : g_first
      assign src_v    = valid_i;
      assign src_num  = dividend_i;
      assign src_rem  = '0;
      assign src_dsr  = divisor_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_v    = v_q[s-1];
      assign src_num  = num_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_dsr  = dsr_q[s-1];
      assign src_side = side_q[s-1];
    end

    // Dividend bits shift out the top, quotient bits shift in at the bottom
    always_comb begin
      logic [RW:0] t;
      nxt_num = src_num;
      nxt_rem = src_rem;
      for (int j = 0; j < BitsPerStage; j++) begin
        t       = {nxt_rem, nxt_num[NW-1]};
        nxt_num = {nxt_num[NW-2:0], 1'b0};
        if (t >= {1'b0, src_dsr}) begin
          nxt_rem    = RW'(t - {1'b0, src_dsr});
          nxt_num[0] = 1'b1;
        end else begin
          nxt_rem = t[RW-1:0];
        end
      end
    end

    assign rdy[s] = !v_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_v) begin
        num_q[s]  <= nxt_num;
        rem_q[s]  <= nxt_rem;
        dsr_q[s]  <= src_dsr;
        side_q[s] <= src_side;
      end
    end
  end

  assign valid_o    = v_q[NumStages-1];
  assign quotient_o = num_q[NumStages-1];
  assign side_o     = side_q[NumStages-1];

endmodule

@@ rtl/timer_divider_setting_calc_top.sv @@
// ----------------------------------------------------------------------------
// timer_divider_setting_calc_top
// Turns timer period requests into 16-bit timer channel settings.
// ----------------------------------------------------------------------------
// Usage:
//   Program clock_hz (0x0) and has_primary_prescaler (0x4) over the APB port
//   while no request is in flight. Send requests on req_i (cmd, period_us,
//   reload); each yields one word on res_o (status, mode_word,
//   primary_prescale, reference) in request order.
// Pipeline: a request passes the leading-bit search stage, the period
//   scaling stage, the divider stages and the output register, in that
//   order, before its word appears on res_o.
// Throughput: one word per cycle while res_o is ready. Every stage has
//   its own valid bit and ready, so empty stages keep filling while res_o
//   is stalled; a stall holds every full stage and drops nothing.
// Reset: clears all valid bits, clock_hz to 0 and has_primary_prescaler
//   to 1.
// ----------------------------------------------------------------------------
module timer_divider_setting_calc_top #(
  parameter int unsigned DivBitsPerStage = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  tdsc_req_if.sink     req_i,
  tdsc_res_if.source   res_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]          clock_hz_q;
  logic                 has_pp_q;
  tdsc_pkg::reg_idx_e   reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = tdsc_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= '0;
      has_pp_q   <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        tdsc_pkg::RegClockHz:    clock_hz_q <= pwdata;
        tdsc_pkg::RegHasPrimary: has_pp_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tdsc_pkg::RegClockHz:    prdata = clock_hz_q;
      tdsc_pkg::RegHasPrimary: prdata = {31'd0, has_pp_q};
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage A: leading set bit of each 16-bit chunk of the period
  // --------------------------------------------------------------------------
  logic        a_v_q, a_rdy;
  logic        a_cmd_q, a_reload_q;
  logic [63:0] a_period_q;
  logic [3:0]  a_nz_q, a_nz_d;
  logic [3:0]  a_pos_q [4];
  logic [3:0]  a_pos_d [4];
  logic        b_v_q, b_rdy;

  always_comb begin
    logic [15:0] chunk;
    for (int c = 0; c < 4; c++) begin
      chunk      = req_i.period_us[16*c +: 16];
      a_nz_d[c]  = |chunk;
      a_pos_d[c] = '0;
      for (int k = 0; k < 16; k++) begin
        if (chunk[k]) a_pos_d[c] = 4'(k);
      end
    end
  end

  assign a_rdy       = !a_v_q || b_rdy;
  assign req_i.ready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_rdy) begin
      a_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && req_i.valid) begin
      a_cmd_q    <= req_i.cmd;
      a_reload_q <= req_i.reload;
      a_period_q <= req_i.period_us;
      a_nz_q     <= a_nz_d;
      a_pos_q    <= a_pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: bit length, scale shift, tick rate and reference value
  // --------------------------------------------------------------------------
  logic [6:0]                       blen, sh;
  logic                             wide;
  logic [tdsc_pkg::DivisorW-1:0]    b_rate_d, b_rate_q;
  tdsc_pkg::side_t                  b_side_d, b_side_q;
  logic                             div_in_rdy;

  always_comb begin
    blen = '0;
    for (int c = 0; c < 4; c++) begin
      if (a_nz_q[c]) blen = 7'(16 * c) + {3'd0, a_pos_q[c]} + 7'd1;
    end
    wide = blen > tdsc_pkg::ScaledTopBit;
    sh   = wide ? (blen - tdsc_pkg::ScaledTopBit) : 7'd0;

    b_side_d.reload = a_reload_q;
    if (a_cmd_q) begin
      b_rate_d           = tdsc_pkg::TickRateHz;
      b_side_d.rate_zero = 1'b0;
      b_side_d.ref_val   = a_period_q[15:0];
    end else begin
      b_rate_d           = tdsc_pkg::TickRateHz >> sh;
      b_side_d.rate_zero = blen >= tdsc_pkg::RateZeroLen;
      b_side_d.ref_val   = 16'(a_period_q >> sh);
    end
  end

  assign b_rdy = !b_v_q || div_in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_rdy) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy && a_v_q) begin
      b_rate_q <= b_rate_d;
      b_side_q <= b_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: clock_hz / tick rate
  // --------------------------------------------------------------------------
  logic                              dv_v, f_rdy;
  logic [tdsc_pkg::DividendW-1:0]    dv_q;
  tdsc_pkg::side_t                   dv_side;

  tdsc_div_pipe #(
    .BitsPerStage (DivBitsPerStage)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_v_q),
    .ready_o    (div_in_rdy),
    .dividend_i (clock_hz_q),
    .divisor_i  (b_rate_q),
    .side_i     (b_side_q),
    .valid_o    (dv_v),
    .ready_i    (f_rdy),
    .quotient_o (dv_q),
    .side_o     (dv_side)
  );

  // --------------------------------------------------------------------------
  // Output stage: range check, clock select and prescale split
  // --------------------------------------------------------------------------
  logic [31:0]        limit, d2;
  logic               slow;
  logic [7:0]         sps, psr;
  tdsc_pkg::status_e  st_d;
  logic [15:0]        mode_d, ref_d;
  logic [7:0]         psr_d;

  logic               res_v_q;
  logic [1:0]         res_st_q;
  logic [15:0]        res_mode_q, res_ref_q;
  logic [7:0]         res_psr_q;

  always_comb begin
    limit = has_pp_q ? tdsc_pkg::DivLimitFull : (tdsc_pkg::DivLimitFull >> 8);
    slow  = dv_q > (limit >> 4);
    d2    = slow ? (dv_q >> 4) : dv_q;
    // Zero divider wraps the secondary prescale to 255
    if (d2 <= 32'd256) begin
      psr = 8'd0;
      sps = 8'(d2 - 32'd1);
    end else begin
      psr = 8'd255;
      sps = 8'((d2 >> 8) - 32'd1);
    end

    mode_d = '0;
    psr_d  = '0;
    ref_d  = '0;
    if (dv_side.rate_zero) begin
      st_d = tdsc_pkg::StRateZero;
    end else if (dv_q > limit) begin
      st_d = tdsc_pkg::StDivRange;
    end else begin
      st_d        = tdsc_pkg::StOk;
      mode_d      = {sps, 3'd0, 1'b1, dv_side.reload,
                     slow ? tdsc_pkg::ClkSlow : tdsc_pkg::ClkNormal, 1'b0};
      psr_d       = psr;
      ref_d       = dv_side.ref_val;
    end
  end

  assign f_rdy = !res_v_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (f_rdy) begin
      res_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && dv_v) begin
      res_st_q   <= st_d;
      res_mode_q <= mode_d;
      res_psr_q  <= psr_d;
      res_ref_q  <= ref_d;
    end
  end

  assign res_o.valid            = res_v_q;
  assign res_o.status           = res_st_q;
  assign res_o.mode_word        = res_mode_q;
  assign res_o.primary_prescale = res_psr_q;
  assign res_o.reference        = res_ref_q;

`ifndef ASSERT_OFF
  // Error words carry no settings
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != tdsc_pkg::StOk) |->
      (res_o.mode_word == 16'd0) && (res_o.primary_prescale == 8'd0) &&
      (res_o.reference == 16'd0))
    else $error("error result with nonzero settings");

  // Good words enable the reference interrupt and pick a legal clock
  a_ok_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == tdsc_pkg::StOk) |->
      res_o.mode_word[4] &&
      ((res_o.mode_word[2:1] == tdsc_pkg::ClkNormal) ||
       (res_o.mode_word[2:1] == tdsc_pkg::ClkSlow)))
    else $error("bad mode word on good result");

  // Without a primary prescaler the divider never needs it
  a_no_pp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !has_pp_q && (res_o.status == tdsc_pkg::StOk) |->
      (res_o.primary_prescale == 8'd0))
    else $error("primary prescale used with small divider limit");

  // Hold a stalled result word
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=>
      res_o.valid && $stable(res_o.status) && $stable(res_o.mode_word) &&
      $stable(res_o.primary_prescale) && $stable(res_o.reference))
    else $error("result word changed while stalled");
`endif

endmodule

@@ tb/tdsc_setting_checker.sv @@
// ----------------------------------------------------------------------------
// tdsc_setting_checker
// Watches the APB port and both channels of the timer divider setting
// calculator. Keeps its own copy of clock_hz and has_primary_prescaler,
// works out the timer settings for every accepted request and compares
// each result word, field by field, with the oldest outstanding setting.
// Register reads are checked against the same copy.
// ----------------------------------------------------------------------------
module tdsc_setting_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  tdsc_req_if         req,
  tdsc_res_if         res,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct {
    tdsc_pkg::status_e status;
    logic [15:0]       mode_word;
    logic [7:0]        primary_prescale;
    logic [15:0]       reference;
  } timer_setting_t;

  logic [31:0]    clock_hz_cfg;
  logic           has_primary_cfg;
  timer_setting_t expected_settings[$];
  int unsigned    mismatches = 0;

  function automatic timer_setting_t calc_timer_setting(logic cmd, logic [63:0] period,
                                                        logic reload);
    timer_setting_t setting;
    logic [63:0]    scaled;
    logic [19:0]    rate;
    logic [31:0]    limit;
    logic [31:0]    divider;
    logic [1:0]     clk_sel;
    logic [7:0]     secondary;
    logic [7:0]     primary;
    int unsigned    nbits;
    int unsigned    shift;

    setting = '{tdsc_pkg::StOk, 16'h0, 8'h0, 16'h0};
    rate    = tdsc_pkg::TickRateHz;
    scaled  = period;
    clk_sel = tdsc_pkg::ClkNormal;
    if (!cmd) begin
      nbits = 0;
      for (int i = 0; i < 64; i++) begin
        if (period[i]) nbits = i + 1;
      end
      // shift the period down to 15 bits and the tick rate along with it
      if (nbits > tdsc_pkg::ScaledTopBit) begin
        shift  = nbits - tdsc_pkg::ScaledTopBit;
        rate   = tdsc_pkg::TickRateHz >> shift;
        scaled = period >> shift;
      end
      if (rate == '0) begin
        setting.status = tdsc_pkg::StRateZero;
        return setting;
      end
    end

    limit   = has_primary_cfg ? tdsc_pkg::DivLimitFull : tdsc_pkg::DivLimitFull / 256;
    divider = clock_hz_cfg / 32'(rate);
    if (divider > limit) begin
      setting.status = tdsc_pkg::StDivRange;
      return setting;
    end
    if (divider > limit / 16) begin
      clk_sel = tdsc_pkg::ClkSlow;
      divider = divider / 16;
    end
    // a zero divider wraps the secondary prescale to 255
    if (divider <= 256) begin
      primary   = 8'h00;
      secondary = 8'(divider - 1);
    end else begin
      primary   = 8'hFF;
      secondary = 8'(divider / 256 - 1);
    end

    setting.mode_word[2:1]  = clk_sel;
    setting.mode_word[3]    = reload;
    setting.mode_word[4]    = 1'b1;
    setting.mode_word[15:8] = secondary;
    setting.primary_prescale = primary;
    setting.reference        = scaled[15:0];
    return setting;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_setting_t oldest;
    logic [31:0]    reg_value;

    if (!rst_ni) begin
      clock_hz_cfg    = '0;
      has_primary_cfg = 1'b1;
    end else begin
      if (psel && penable && pready) begin
        case (tdsc_pkg::reg_idx_e'(paddr[2]))
          tdsc_pkg::RegClockHz:    reg_value = clock_hz_cfg;
          tdsc_pkg::RegHasPrimary: reg_value = {31'h0, has_primary_cfg};
          default:                 reg_value = '0;
        endcase
        if (pwrite) begin
          case (tdsc_pkg::reg_idx_e'(paddr[2]))
            tdsc_pkg::RegClockHz:    clock_hz_cfg = pwdata;
            tdsc_pkg::RegHasPrimary: has_primary_cfg = pwdata[0];
            default:                 ;
          endcase
        end else if (prdata !== reg_value) begin
          $error("prdata: expected 0x%0h, got 0x%0h", reg_value, prdata);
          mismatches++;
        end
      end

      if (req.valid && req.ready) begin
        expected_settings.push_back(calc_timer_setting(req.cmd, req.period_us, req.reload));
      end

      if (res.valid && res.ready) begin
        if (expected_settings.size() == 0) begin
          $error("result word with no request outstanding: status %0d mode_word 0x%0h",
                 res.status, res.mode_word);
          mismatches++;
        end else begin
          oldest = expected_settings.pop_front();
          check_field("status", 16'(oldest.status), 16'(res.status));
          check_field("mode_word", oldest.mode_word, res.mode_word);
          check_field("primary_prescale", 16'(oldest.primary_prescale),
                      16'(res.primary_prescale));
          check_field("reference", oldest.reference, res.reference);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_settings.size();
  end

endmodule

@@ tb/tb_timer_divider_setting_calc_top.sv @@
// ----------------------------------------------------------------------------
// tb_timer_divider_setting_calc_top
// Drives timer period requests through the setting calculator under a
// series of clock_hz / has_primary_prescaler settings: a directed set of
// corner requests first, then random requests in bursts against a
// stalling result receiver. Checking is done by tdsc_setting_checker.
// ----------------------------------------------------------------------------
module tb_timer_divider_setting_calc_top;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned NumPhases     = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_kind = 0;
  int unsigned cycle_cnt = 0;

  tdsc_req_if req_if ();
  tdsc_res_if res_if ();

  timer_divider_setting_calc_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .res_o   (res_if)
  );

  tdsc_setting_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req        (req_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result receiver: switch between randomly chosen stall patterns
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (stall_left == 0) begin
      stall_left <= $urandom_range(20, 120);
      stall_kind <= $urandom_range(0, 3);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      0:       res_if.ready <= 1'b1;
      1:       res_if.ready <= 1'($urandom_range(0, 1));
      2:       res_if.ready <= (cycle_cnt % 5 == 0);
      default: res_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_period_request(logic cmd, logic [63:0] period, logic reload);
    int unsigned gap;

    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                               : $urandom_range(1, 16);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= cmd;
    req_if.period_us <= period;
    req_if.reload    <= reload;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // drop valid and hold until every outstanding word has come back
  task automatic drain_results(int unsigned settle);
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, tdsc_pkg::reg_idx_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_timer_config(logic [31:0] clock_hz, logic has_primary);
    drain_results(SettleCycles);
    apb_access(1'b1, tdsc_pkg::RegClockHz, clock_hz);
    apb_access(1'b1, tdsc_pkg::RegHasPrimary, {31'h0, has_primary});
    apb_access(1'b0, tdsc_pkg::RegClockHz, '0);
    apb_access(1'b0, tdsc_pkg::RegHasPrimary, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random period whose bit length is spread so every shift amount occurs
  function automatic logic [63:0] rand_period();
    int unsigned nbits;
    logic [63:0] value;

    nbits = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 34) : $urandom_range(35, 64);
    value = {$urandom, $urandom};
    if (nbits == 0) return '0;
    value = value & ((64'(1) << nbits) - 1);
    value[nbits-1] = 1'b1;
    return value;
  endfunction

  initial begin
    logic [31:0] phase_clock[NumPhases];
    logic        phase_primary[NumPhases];

    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_if.valid     <= 1'b0;
    req_if.cmd       <= 1'b0;
    req_if.period_us <= '0;
    req_if.reload    <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // largest clock with the full divider range
    set_timer_config(32'hFFFF_FFFF, 1'b1);
    send_period_request(1'b0, 64'h0, 1'b0);
    send_period_request(1'b0, 64'h1, 1'b1);
    send_period_request(1'b0, 64'h7FFF, 1'b0);
    send_period_request(1'b0, 64'h8000, 1'b1);
    send_period_request(1'b0, 64'hFFFF, 1'b0);
    send_period_request(1'b0, 64'h1_0000_0000, 1'b0);
    send_period_request(1'b0, 64'h3_FFFF_FFFF, 1'b1);
    send_period_request(1'b0, 64'h4_0000_0000, 1'b0);
    send_period_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_period_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_period_request(1'b1, 64'h0, 1'b0);
    send_period_request(1'b1, 64'hAAAA_0000_0000_5555, 1'b0);

    // zero divider, no primary prescaler
    set_timer_config(32'h0, 1'b0);
    send_period_request(1'b0, 64'd12345, 1'b1);
    send_period_request(1'b1, 64'hFFFF, 1'b0);
    send_period_request(1'b0, 64'(1) << 40, 1'b0);

    // walk the divider across the normal/slow and prescale boundaries
    set_timer_config(32'd16_000_000, 1'b0);
    send_period_request(1'b1, 64'd100, 1'b1);
    send_period_request(1'b0, 64'(1) << 17, 1'b0);
    send_period_request(1'b0, 64'(1) << 18, 1'b1);
    send_period_request(1'b0, 64'(1) << 19, 1'b0);
    send_period_request(1'b0, 64'(1) << 22, 1'b1);
    send_period_request(1'b0, 64'(1) << 23, 1'b0);

    // just over the small divider limit
    set_timer_config(32'hFFFF_FFFF, 1'b0);
    send_period_request(1'b1, 64'h1234, 1'b1);

    phase_clock   = '{32'd100_000_000, 32'h0, 32'hFFFF_FFFF, 32'd16_000_000,
                      32'd1_000_000, $urandom, $urandom_range(0, 2_000_000), 32'd66_000_000};
    phase_primary = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b1};
    for (int p = 0; p < NumPhases; p++) begin
      set_timer_config(phase_clock[p], phase_primary[p]);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 2 && n == ItemsPerPhase / 2) drain_results(0);
        send_period_request(($urandom_range(0, 9) < 3), rand_period(),
                            1'($urandom_range(0, 1)));
      end
    end

    drain_results(24);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
